FILE: hw/rtl/compacting_name_table_core_macros.svh
// Assertion helpers used by the checker module.
`ifndef COMPACTING_NAME_TABLE_CORE_MACROS_SVH
`define COMPACTING_NAME_TABLE_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CNTAB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define CNTAB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/cntab_pkg.sv
`timescale 1ns / 1ps

package cntab_pkg;

   localparam int FUNC_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int KEY_W       = 64;
   localparam int SIZE_W      = 31;
   localparam int SLOT_W      = 5;
   localparam int HELD_W      = 6;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_EXISTS   = 3'd2,
      ST_DELETED  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_FOUND    = 3'd5,
      ST_LISTED   = 3'd6,
      ST_EMPTY    = 3'd7
   } rsp_status_type;

   // controller -> datapath
   typedef struct packed {
      logic           load;
      logic           rd_step;
      logic           shift_wr;
      logic           append;
      logic           dec;
      logic           emit;
      rsp_status_type emit_status;
      logic           emit_entry;
      logic           emit_last;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic more;
      logic rd_live;
      logic match;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: hw/rtl/cntab_dpath.sv
`timescale 1ns / 1ps

module cntab_dpath #(
   parameter int TABLE_DEPTH = 32,
   parameter int KEY_BITS    = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cntab_pkg::dp_cmd_type          cmd,
   output cntab_pkg::dp_stat_type         stat,
   input  logic [cntab_pkg::KEY_W-1:0]    req_name_key,
   input  logic [cntab_pkg::SIZE_W-1:0]   req_entry_size,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [cntab_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [cntab_pkg::KEY_W-1:0]    rsp_found_key,
   output logic [cntab_pkg::SIZE_W-1:0]   rsp_found_size,
   output logic [cntab_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [cntab_pkg::HELD_W-1:0]   rsp_entries_held,
   output logic                           rsp_last
);
   import cntab_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = $clog2(TABLE_DEPTH + 1);

   logic [KEY_BITS-1:0] key_mem  [TABLE_DEPTH];
   logic [SIZE_W-1:0]   size_mem [TABLE_DEPTH];

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       count_ff, count_in;
   logic [AW-1:0]       prev_idx_ff, prev_idx_in;
   logic                rd_live_ff, rd_live_in;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [SIZE_W-1:0]   rd_size_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [STATUS_BITS-1:0] out_status_ff, out_status_in;
   logic [KEY_W-1:0]       out_key_ff, out_key_in;
   logic [SIZE_W-1:0]      out_size_ff, out_size_in;
   logic [SLOT_W-1:0]      out_slot_ff, out_slot_in;
   logic [HELD_W-1:0]      out_held_ff, out_held_in;
   logic                   out_last_ff, out_last_in;

   logic                more;
   logic                out_free;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_key;
   logic [SIZE_W-1:0]   wr_size;

   always_comb begin
      more     = (idx_ff < count_ff);
      out_free = !out_valid_ff || rsp_ready;
      rd_en    = cmd.rd_step && more;
      rd_addr  = idx_ff[AW-1:0];
      wr_en    = cmd.append || (cmd.shift_wr && rd_live_ff);
      if (cmd.append) begin
         wr_addr = count_ff[AW-1:0];
         wr_key  = key_ff;
         wr_size = size_ff;
      end else begin
         wr_addr = prev_idx_ff - AW'(1);
         wr_key  = rd_key_ff;
         wr_size = rd_size_ff;
      end

      stat.full     = (count_ff == IW'(TABLE_DEPTH));
      stat.empty    = (count_ff == '0);
      stat.more     = more;
      stat.rd_live  = rd_live_ff;
      stat.match    = (rd_key_ff == key_ff);
      stat.out_free = out_free;
   end

   always_comb begin
      key_in      = key_ff;
      size_in     = size_ff;
      idx_in      = idx_ff;
      prev_idx_in = prev_idx_ff;
      rd_live_in  = rd_live_ff;
      count_in    = count_ff;
      if (cmd.load) begin
         key_in     = req_name_key[KEY_BITS-1:0];
         size_in    = req_entry_size;
         idx_in     = '0;
         rd_live_in = 1'b0;
      end else if (cmd.rd_step) begin
         rd_live_in = more;
         if (more) begin
            idx_in      = idx_ff + IW'(1);
            prev_idx_in = idx_ff[AW-1:0];
         end
      end
      if (cmd.append) begin
         count_in = count_ff + IW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - IW'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_size_in   = out_size_ff;
      out_slot_in   = out_slot_ff;
      out_held_in   = out_held_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.emit_status;
         out_key_in    = cmd.emit_entry ? KEY_W'(rd_key_ff) : '0;
         out_size_in   = cmd.emit_entry ? rd_size_ff : '0;
         out_slot_in   = cmd.emit_entry ? SLOT_W'(prev_idx_ff) : '0;
         out_held_in   = HELD_W'(count_ff);
         out_last_in   = cmd.emit_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_live_ff   <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_live_ff   <= rd_live_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      size_ff       <= size_in;
      prev_idx_ff   <= prev_idx_in;
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_size_ff   <= out_size_in;
      out_slot_ff   <= out_slot_in;
      out_held_ff   <= out_held_in;
      out_last_ff   <= out_last_in;
   end

   // table storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         size_mem[wr_addr] <= wr_size;
      end
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_size_ff <= size_mem[rd_addr];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_found_key    = out_key_ff;
   assign rsp_found_size   = out_size_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_entries_held = out_held_ff;
   assign rsp_last         = out_last_ff;

endmodule

FILE: hw/rtl/cntab_ctrl.sv
`timescale 1ns / 1ps

module cntab_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cntab_pkg::FUNC_BITS-1:0]  req_func,
   input  cntab_pkg::dp_stat_type           stat,
   output cntab_pkg::dp_cmd_type            cmd
);
   import cntab_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_LIST  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   func_type       func_ff, func_in;
   rsp_status_type status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      cmd             = '0;
      cmd.emit_status = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               func_in  = func_type'(req_func);
               unique case (func_type'(req_func))
                  FUNC_INSERT: begin
                     if (stat.full) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  FUNC_DELETE, FUNC_SEARCH: begin
                     state_in = S_SCAN;
                  end
                  FUNC_LIST: begin
                     if (stat.empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            priority if (stat.rd_live && stat.match) begin
               unique case (func_ff)
                  FUNC_INSERT: begin
                     status_in = ST_EXISTS;
                     state_in  = S_RESP;
                  end
                  FUNC_SEARCH: begin
                     status_in = ST_FOUND;
                     state_in  = S_RESP;
                  end
                  FUNC_DELETE: begin
                     cmd.rd_step = 1'b1;
                     state_in    = S_SHIFT;
                  end
                  FUNC_LIST: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else if (stat.more) begin
               cmd.rd_step = 1'b1;
            end else if (func_ff == FUNC_INSERT) begin
               cmd.append = 1'b1;
               status_in  = ST_INSERTED;
               state_in   = S_RESP;
            end else begin
               status_in = ST_NOTFOUND;
               state_in  = S_RESP;
            end
         end

         S_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (stat.more) begin
               cmd.rd_step = 1'b1;
            end else begin
               cmd.dec   = 1'b1;
               status_in = ST_DELETED;
               state_in  = S_RESP;
            end
         end

         S_LIST: begin
            if (!stat.rd_live) begin
               cmd.rd_step = 1'b1;
            end else if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_LISTED;
               cmd.emit_entry  = 1'b1;
               cmd.emit_last   = !stat.more;
               if (stat.more) begin
                  cmd.rd_step = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESP: begin
            if (stat.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_entry = (status_ff == ST_FOUND);
               cmd.emit_last  = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      status_ff <= status_in;
   end

endmodule

FILE: hw/rtl/compacting_name_table_core.sv
// Requests are handled one at a time; the single read port of the table, scanned one entry
//   per cycle, sets the pace. The result register frees the input early.
// List gives one entry per cycle while the result output is not stalled.
// Reset (synchronous): clears the sequencer, entry count and result valid;
//   table contents are not cleared and no clearing pass runs.
`timescale 1ns / 1ps

module compacting_name_table_core #(
   parameter int TABLE_DEPTH = 32,
   parameter int KEY_BITS    = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cntab_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [cntab_pkg::KEY_W-1:0]       req_name_key,
   input  logic [cntab_pkg::SIZE_W-1:0]      req_entry_size,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cntab_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [cntab_pkg::KEY_W-1:0]       rsp_found_key,
   output logic [cntab_pkg::SIZE_W-1:0]      rsp_found_size,
   output logic [cntab_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [cntab_pkg::HELD_W-1:0]      rsp_entries_held,
   output logic                              rsp_last
);
   import cntab_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cntab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd)
   );

   cntab_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_name_key     (req_name_key),
      .req_entry_size   (req_entry_size),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_found_key    (rsp_found_key),
      .rsp_found_size   (rsp_found_size),
      .rsp_slot         (rsp_slot),
      .rsp_entries_held (rsp_entries_held),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: hw/rtl/cntab_checker.sv
`timescale 1ns / 1ps
`include "compacting_name_table_core_macros.svh"

module cntab_checker #(
   parameter int TABLE_DEPTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [cntab_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [cntab_pkg::KEY_W-1:0]       rsp_found_key,
   input logic [cntab_pkg::SIZE_W-1:0]      rsp_found_size,
   input logic [cntab_pkg::SLOT_W-1:0]      rsp_slot,
   input logic [cntab_pkg::HELD_W-1:0]      rsp_entries_held,
   input logic                              rsp_last
);
   import cntab_pkg::*;

   logic stalled;
   logic no_entry;

   assign stalled  = rsp_valid && !rsp_ready;
   assign no_entry = rsp_valid && (rsp_status != ST_FOUND) && (rsp_status != ST_LISTED);

   `CNTAB_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_status) && $stable(rsp_found_key) && $stable(rsp_last), "result item changed while stalled")

   `CNTAB_ASSERT_NOW(a_unused_zero, clock, reset, no_entry, (rsp_found_key == '0) && (rsp_found_size == '0) && (rsp_slot == '0), "entry fields not zero")

   `CNTAB_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && (rsp_status != ST_LISTED), rsp_last, "single result without last")

   `CNTAB_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_entries_held == HELD_W'(TABLE_DEPTH), "full reported below depth")

   `CNTAB_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid && (rsp_status == ST_EMPTY), rsp_entries_held == '0, "empty reported with entries")

endmodule

bind compacting_name_table_core cntab_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_cntab_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_found_key    (rsp_found_key),
   .rsp_found_size   (rsp_found_size),
   .rsp_slot         (rsp_slot),
   .rsp_entries_held (rsp_entries_held),
   .rsp_last         (rsp_last)
);
